FILE: design/dedq_pkg.sv
// shared types and constants of the delayed event deadline queue
package dedq_pkg;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_TRIGGER = 2'd0,
    OP_TICK    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_LEAVE   = 2'd3
  } dedq_op_e;

  // register word index of the event duration
  localparam logic DEDQ_REG_DURATION = 1'b0;
  localparam logic [31:0] DEDQ_DURATION_RESET = 32'd10000;
  localparam logic [3:0] DEDQ_FIRED_MAX = 4'd15;

  typedef struct packed {
    dedq_op_e    operation;
    logic [31:0] now;
    logic [31:0] delay_ms;
  } dedq_in_t;

  typedef struct packed {
    logic        event_active;
    logic [31:0] window_start;
    logic [31:0] window_end;
    logic [3:0]  queued_count;
    logic [30:0] next_due_in_ms;
    logic [3:0]  fired_count;
    logic        delay_skipped;
  } dedq_out_t;

endpackage

FILE: design/dedq_alu.sv
// shared 32-bit add/subtract unit used for sums and wrap-safe compares
module dedq_alu (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        sub_i,
  output logic [31:0] sum_o,
  output logic        neg_o,
  output logic        pos_o
);
  import dedq_pkg::*;

  logic [31:0] b_eff;

  // two's complement subtract when sub_i is set
  assign b_eff = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_eff + {31'd0, sub_i};

  // sign of the wrapping difference, and strictly positive
  assign neg_o = sum_o[31];
  assign pos_o = (sum_o != 32'd0) && !sum_o[31];
endmodule

FILE: design/dedq_store.sv
// deadline ring memory with one write port and one registered read port
module dedq_store #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned AW = 3
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [31:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [31:0]   rd_data_o
);
  import dedq_pkg::*;

  logic [31:0] mem_q [QUEUE_DEPTH];
  logic [31:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule

FILE: design/delayed_event_deadline_queue_unit.sv
// top level of the delayed event deadline queue with its sequencer
//
// Keeps up to QUEUE_DEPTH event deadlines sorted earliest first in a ring
// memory, plus one active event window. Each input transaction (valid/ready)
// carries an operation, the current time and a delay; it yields exactly one
// result transaction with the window, queue fill, time to next deadline,
// fired count and skip flag.
// The input is ready only while the sequencer is idle. One shared adder does
// every time sum and wrap-safe compare, and the memory read is registered, so
// each entry visited takes a read state and a compare state. A sorted insert
// runs END and SUM, then RD and CMP for each entry it visits; a tick runs END
// and CLOSE, then PRD and PCMP for each deadline it checks; an immediate
// trigger, a clear and a leave run END only. All then pass NEXT, NCMP while a
// deadline is queued, and DONE; the next input can be taken in the cycle after
// the result is loaded. The result sits in an output register; a stalled
// receiver does not block the next input, but a second result waits in the
// sequencer until the output register is taken. Reset empties the queue (fill
// count and head only), closes the window and sets the duration register to
// 10000 ms.
// The duration register is written through the APB port at address 0.
module delayed_event_deadline_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dedq_pkg::dedq_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dedq_pkg::dedq_out_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import dedq_pkg::*;

  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned PW = FW + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_END,
    S_SUM,
    S_RD,
    S_CMP,
    S_CLOSE,
    S_PRD,
    S_PCMP,
    S_NEXT,
    S_NCMP,
    S_DONE
  } state_e;

  state_e        state_q, state_d;
  dedq_op_e      op_q, op_d;
  logic [31:0]   now_q, now_d;
  logic [31:0]   delay_q, delay_d;
  logic [31:0]   end_q, end_d;
  logic [31:0]   at_q, at_d;
  logic [FW-1:0] idx_q, idx_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [AW-1:0] head_q, head_d;
  logic          open_q, open_d;
  logic [31:0]   open_time_q, open_time_d;
  logic [31:0]   close_time_q, close_time_d;
  logic [3:0]    fired_q, fired_d;
  logic          skipped_q, skipped_d;
  logic [30:0]   next_due_q, next_due_d;
  logic [31:0]   dur_q;
  logic          out_valid_q, out_valid_d;
  dedq_out_t     out_data_q, out_data_d;

  logic [31:0]   alu_a, alu_b, alu_sum;
  logic          alu_sub, alu_neg, alu_pos;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data, rd_data;
  logic [FW-1:0] rel_k;
  logic [FW-1:0] rel_w;
  logic [AW-1:0] phys_k, phys_w;
  logic          cfg_wr;

  // ring position of a queue slot, head plus offset modulo depth
  function automatic logic [AW-1:0] ring_pos(logic [AW-1:0] head, logic [FW-1:0] k);
    logic [PW-1:0] s;
    s = PW'(head) + PW'(k);
    if (s >= PW'(QUEUE_DEPTH)) begin
      s = s - PW'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign phys_k = ring_pos(head_q, rel_k);
  assign phys_w = ring_pos(head_q, rel_w);

  dedq_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum),
    .neg_o (alu_neg),
    .pos_o (alu_pos)
  );

  dedq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == DEDQ_REG_DURATION);
  assign prdata = (paddr[2] == DEDQ_REG_DURATION) ? dur_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= DEDQ_DURATION_RESET;
    end else if (cfg_wr) begin
      dur_q <= pwdata;
    end
  end

  // operand selection for the shared adder
  always_comb begin
    alu_a   = now_q;
    alu_b   = dur_q;
    alu_sub = 1'b0;
    case (state_q)
      S_SUM: begin
        alu_b = delay_q;
      end
      S_CLOSE: begin
        alu_b   = close_time_q;
        alu_sub = 1'b1;
      end
      S_CMP: begin
        alu_a   = rd_data;
        alu_b   = at_q;
        alu_sub = 1'b1;
      end
      S_PCMP: begin
        alu_b   = rd_data;
        alu_sub = 1'b1;
      end
      S_NCMP: begin
        alu_a   = rd_data;
        alu_b   = now_q;
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    now_d        = now_q;
    delay_d      = delay_q;
    end_d        = end_q;
    at_d         = at_q;
    idx_d        = idx_q;
    fill_d       = fill_q;
    head_d       = head_q;
    open_d       = open_q;
    open_time_d  = open_time_q;
    close_time_d = close_time_q;
    fired_d      = fired_q;
    skipped_d    = skipped_q;
    next_due_d   = next_due_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rel_k        = '0;
    rel_w        = idx_q;
    wr_addr      = phys_w;
    wr_data      = at_q;
    rd_addr      = phys_k;

    // output register drains independently of the sequencer
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = in_data_i.operation;
          now_d     = in_data_i.now;
          delay_d   = in_data_i.delay_ms;
          fired_d   = '0;
          skipped_d = 1'b0;
          state_d   = S_END;
        end
      end
      // window end for any firing, then dispatch on the operation
      S_END: begin
        end_d = alu_sum;
        case (op_q)
          OP_TRIGGER: begin
            if ((delay_q != 32'd0) && (fill_q < FW'(QUEUE_DEPTH))) begin
              idx_d   = fill_q;
              state_d = S_SUM;
            end else begin
              skipped_d = (delay_q != 32'd0);
              if (!open_q) begin
                open_time_d = now_q;
              end
              close_time_d = alu_sum;
              open_d       = 1'b1;
              fired_d      = 4'd1;
              state_d      = S_NEXT;
            end
          end
          OP_TICK: begin
            state_d = S_CLOSE;
          end
          OP_CLEAR: begin
            fill_d  = '0;
            state_d = S_NEXT;
          end
          default: begin
            open_d  = 1'b0;
            state_d = S_NEXT;
          end
        endcase
      end
      S_SUM: begin
        at_d    = alu_sum;
        state_d = S_RD;
      end
      // sorted insert: look at the slot just below the hole
      S_RD: begin
        if (idx_q == '0) begin
          wr_en   = 1'b1;
          fill_d  = fill_q + FW'(1);
          state_d = S_NEXT;
        end else begin
          rel_k   = idx_q - FW'(1);
          rd_en   = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        wr_en = 1'b1;
        if (alu_pos) begin
          wr_data = rd_data;
          idx_d   = idx_q - FW'(1);
          state_d = S_RD;
        end else begin
          fill_d  = fill_q + FW'(1);
          state_d = S_NEXT;
        end
      end
      // tick: close an expired window first
      S_CLOSE: begin
        if (open_q && !alu_neg) begin
          open_d = 1'b0;
        end
        state_d = S_PRD;
      end
      S_PRD: begin
        if (fill_q == '0) begin
          state_d = S_NEXT;
        end else begin
          rd_en   = 1'b1;
          state_d = S_PCMP;
        end
      end
      // pop and fire a due head deadline
      S_PCMP: begin
        if (!alu_neg) begin
          head_d = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
          fill_d = fill_q - FW'(1);
          if (!open_q) begin
            open_time_d = now_q;
          end
          close_time_d = end_q;
          open_d       = 1'b1;
          if (fired_q != DEDQ_FIRED_MAX) begin
            fired_d = fired_q + 4'd1;
          end
          state_d = S_PRD;
        end else begin
          state_d = S_NEXT;
        end
      end
      // time until the earliest deadline
      S_NEXT: begin
        if (fill_q == '0) begin
          next_due_d = '0;
          state_d    = S_DONE;
        end else begin
          rd_en   = 1'b1;
          state_d = S_NCMP;
        end
      end
      S_NCMP: begin
        next_due_d = alu_pos ? alu_sum[30:0] : 31'd0;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                = 1'b1;
          out_data_d.event_active    = open_q;
          out_data_d.window_start    = open_time_q;
          out_data_d.window_end      = close_time_q;
          out_data_d.queued_count    = 4'(fill_q);
          out_data_d.next_due_in_ms  = next_due_q;
          out_data_d.fired_count     = fired_q;
          out_data_d.delay_skipped   = skipped_q;
          state_d                    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      head_q       <= '0;
      open_q       <= 1'b0;
      open_time_q  <= '0;
      close_time_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      head_q       <= head_d;
      open_q       <= open_d;
      open_time_q  <= open_time_d;
      close_time_q <= close_time_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // transaction payload and work registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    now_q      <= now_d;
    delay_q    <= delay_d;
    end_q      <= end_d;
    at_q       <= at_d;
    idx_q      <= idx_d;
    fired_q    <= fired_d;
    skipped_q  <= skipped_d;
    next_due_q <= next_due_d;
    out_data_q <= out_data_d;
  end
endmodule

FILE: design/dedq_checker.sv
// port-level checks of the deadline queue result channel, bound to the top
module dedq_checker #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input dedq_pkg::dedq_out_t out_data_o
);
  import dedq_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // never more firings than queue slots plus one
  a_fired_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.fired_count <= QUEUE_DEPTH + 1))
    else $error("fired count out of range");

  // a skipped delay fires exactly once and opens the window
  a_skip_fires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.delay_skipped |->
      (out_data_o.fired_count == 4'd1) && out_data_o.event_active)
    else $error("skipped delay did not fire");

  // any firing leaves the window open
  a_fire_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.fired_count != 4'd0) |-> out_data_o.event_active)
    else $error("fired event with closed window");
endmodule

bind delayed_event_deadline_queue_unit dedq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_dedq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: verif/dedq_deadline_checker.sv
// result predictor and comparator for the delayed event deadline queue
module dedq_deadline_checker #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  dedq_pkg::dedq_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  dedq_pkg::dedq_out_t out_data_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic [31:0]         prdata,
  input  logic                pready,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  compared_o,
  output int                  skipped_o,
  output int                  popped_o
);
  import dedq_pkg::*;

  localparam logic [2:0] DURATION_ADDR = {DEDQ_REG_DURATION, 2'b00};

  // predicted block state
  logic [31:0] deadlines [QUEUE_DEPTH];
  int unsigned fill;
  logic        window_open;
  logic [31:0] window_start;
  logic [31:0] window_end;
  logic [31:0] duration;

  // predicted results waiting for their transaction
  dedq_out_t   expected_reports [$];
  dedq_out_t   oldest;
  int          mismatches = 0;
  int          outstanding = 0;
  int          compared = 0;
  int          skip_total = 0;
  int          pop_total = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;
  assign compared_o   = compared;
  assign skipped_o    = skip_total;
  assign popped_o     = pop_total;

  // a - b is negative as a signed 32-bit difference
  function automatic logic behind(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  function automatic logic ahead(input logic [31:0] a, input logic [31:0] b);
    return (a != b) && !behind(a, b);
  endfunction

  // open the window, or push its end out when already open
  function automatic void fire_event(input logic [31:0] stamp);
    if (!window_open) begin
      window_start = stamp;
    end
    window_end  = stamp + duration;
    window_open = 1'b1;
  endfunction

  // apply one input transaction to the predicted state and build its result
  function automatic dedq_out_t predict_report(input dedq_in_t item);
    dedq_out_t   rep;
    logic [31:0] due_at;
    logic [31:0] wait_ms;
    int          slot;
    int          fired;
    logic        skipped;
    fired   = 0;
    skipped = 1'b0;
    case (item.operation)
      OP_TRIGGER: begin
        if (item.delay_ms != '0 && fill < QUEUE_DEPTH) begin
          due_at = item.now + item.delay_ms;
          slot   = fill;
          // later deadlines shift up, equal ones stay in front
          while (slot > 0 && ahead(deadlines[slot-1], due_at)) begin
            deadlines[slot] = deadlines[slot-1];
            slot--;
          end
          deadlines[slot] = due_at;
          fill++;
        end else begin
          skipped = (item.delay_ms != '0);
          fire_event(item.now);
          fired = 1;
        end
      end
      OP_TICK: begin
        // expired window closes before due deadlines fire
        if (window_open && !behind(item.now, window_end)) begin
          window_open = 1'b0;
        end
        while (fill > 0 && !behind(item.now, deadlines[0])) begin
          for (slot = 1; slot < fill; slot++) begin
            deadlines[slot-1] = deadlines[slot];
          end
          fill--;
          fire_event(item.now);
          fired++;
          pop_total++;
        end
      end
      OP_CLEAR: fill = 0;
      OP_LEAVE: window_open = 1'b0;
      default: ;
    endcase
    if (skipped) begin
      skip_total++;
    end

    wait_ms = '0;
    if (fill > 0 && ahead(deadlines[0], item.now)) begin
      wait_ms = deadlines[0] - item.now;
    end

    rep.event_active   = window_open;
    rep.window_start   = window_start;
    rep.window_end     = window_end;
    rep.queued_count   = 4'(fill);
    rep.next_due_in_ms = wait_ms[30:0];
    rep.fired_count    = (fired > DEDQ_FIRED_MAX) ? DEDQ_FIRED_MAX : 4'(fired);
    rep.delay_skipped  = skipped;
    return rep;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10) begin
        $display("%s mismatch after %0d results: expected 0x%h, got 0x%h",
                 field, compared, want, got);
      end
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill         = 0;
      window_open  = 1'b0;
      window_start = '0;
      window_end   = '0;
      duration     = DEDQ_DURATION_RESET;
      expected_reports.delete();
      outstanding  = 0;
    end else begin
      // register port access
      if (psel && penable && pready && paddr == DURATION_ADDR) begin
        if (pwrite) begin
          duration = pwdata;
        end else begin
          check_field("duration read-back", duration, prdata);
        end
      end

      // result transaction against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          if (mismatches < 10) begin
            $display("result with no pending prediction: 0x%h", out_data_i);
          end
          mismatches++;
        end else begin
          oldest = expected_reports.pop_front();
          check_field("event_active", 32'(oldest.event_active), 32'(out_data_i.event_active));
          check_field("window_start", oldest.window_start, out_data_i.window_start);
          check_field("window_end", oldest.window_end, out_data_i.window_end);
          check_field("queued_count", 32'(oldest.queued_count), 32'(out_data_i.queued_count));
          check_field("next_due_in_ms", 32'(oldest.next_due_in_ms),
                      32'(out_data_i.next_due_in_ms));
          check_field("fired_count", 32'(oldest.fired_count), 32'(out_data_i.fired_count));
          check_field("delay_skipped", 32'(oldest.delay_skipped),
                      32'(out_data_i.delay_skipped));
          compared++;
        end
      end

      // input transaction
      if (in_valid_i && in_ready_i) begin
        expected_reports.push_back(predict_report(in_data_i));
      end
      outstanding = expected_reports.size();
    end
  end

endmodule

FILE: verif/tb_delayed_event_deadline_queue_unit.sv
// testbench top: clock, reset, stimulus and verdict for the deadline queue unit
module tb_delayed_event_deadline_queue_unit;
  import dedq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam logic [2:0]  DURATION_ADDR = {DEDQ_REG_DURATION, 2'b00};
  localparam int          PHASE_ITEMS = 250;
  localparam int          DRAIN_CYCLES = 30;
  localparam int          STALL_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  dedq_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  dedq_out_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          compared;
  int          skipped;
  int          popped;
  int          items_sent = 0;
  int          settings_done = 1;
  bit          idling_on = 1'b1;

  // 10 unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  delayed_event_deadline_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  dedq_deadline_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .compared_o  (compared),
    .skipped_o   (skipped),
    .popped_o    (popped)
  );

  // present one input transaction, wait for it to be taken, maybe idle after
  task automatic issue(input dedq_op_e op, input logic [31:0] stamp,
                       input logic [31:0] delay);
    dedq_in_t item;
    item.operation = op;
    item.now       = stamp;
    item.delay_ms  = delay;
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    items_sent++;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
  endtask

  // one register port access to the duration register
  task automatic duration_access(input logic write, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= DURATION_ADDR;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // new window length, written once the block has gone quiet
  task automatic set_duration(input logic [31:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    duration_access(1'b1, value);
    duration_access(1'b0, '0);
    settings_done++;
  endtask

  // random stalls on the result side
  initial begin : result_backpressure
    int span;
    forever begin
      @(negedge clk_i);
      span = $urandom_range(1, 17);
      if (idling_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        span = idling_on ? $urandom_range(1, 40) : 1;
      end
      repeat (span - 1) @(negedge clk_i);
    end
  end

  // ends the run when nothing moves for too long
  initial begin : stall_watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] base;
    logic [31:0] clock_now;
    logic [31:0] delay;
    logic [31:0] durations [6];
    int          pick;
    int          sel;
    int          burst_left;
    int          n;
    int          phase;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: field extremes, wrap, equal deadlines, full queue, every operation
    base = 32'hFFFF_FF00;
    issue(OP_LEAVE, '0, '0);
    issue(OP_TICK, '0, '0);
    issue(OP_TRIGGER, base, '0);
    issue(OP_TRIGGER, base, 32'd300);
    issue(OP_TRIGGER, base + 1, 32'd50);
    issue(OP_TRIGGER, base + 2, 32'd298);
    issue(OP_TRIGGER, base + 3, 32'hFFFF_FFFF);
    issue(OP_TRIGGER, base + 3, 32'h8000_0000);
    issue(OP_TRIGGER, base + 4, 32'h7FFF_FFFF);
    issue(OP_TRIGGER, base + 4, 32'd1);
    issue(OP_TRIGGER, base + 5, 32'd5);
    // queue is full here, so this one fires at once
    issue(OP_TRIGGER, base + 6, 32'd7);
    issue(OP_TICK, base + 100, '0);
    issue(OP_CLEAR, base + 101, 32'hFFFF_FFFF);
    // window has expired by now
    issue(OP_TICK, base + 20000, 32'hFFFF_FFFF);
    for (n = 0; n < 8; n++) begin
      issue(OP_TRIGGER, 32'd5000, 32'(1 + (n * 5) % 7));
    end
    // every deadline due on one tick
    issue(OP_TICK, 32'd6000, '0);
    issue(OP_LEAVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // random phases, each under its own window length
    durations[0] = 32'd0;
    durations[1] = 32'hFFFF_FFFF;
    durations[2] = 32'd1;
    durations[3] = $urandom_range(2, 3000);
    durations[4] = $urandom;
    durations[5] = DEDQ_DURATION_RESET;
    burst_left = 0;
    for (phase = 0; phase < 6; phase++) begin
      set_duration(durations[phase]);
      if (phase == 5) begin
        idling_on = 1'b0;
      end
      clock_now = $urandom;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        clock_now += $urandom_range(0, 90);
        pick = $urandom_range(0, 99);
        if (burst_left == 0 && pick < 3) begin
          burst_left = $urandom_range(6, 12);
        end
        if (burst_left > 0) begin
          // trigger bursts fill the queue and spill over
          burst_left--;
          issue(OP_TRIGGER, clock_now, $urandom_range(1, 900));
        end else if (pick < 7) begin
          issue(dedq_op_e'($urandom_range(0, 3)), $urandom, $urandom);
        end else if (pick < 50) begin
          sel = $urandom_range(0, 9);
          delay = (sel == 0) ? 32'd0 : (sel == 1) ? $urandom : $urandom_range(1, 600);
          issue(OP_TRIGGER, clock_now, delay);
        end else if (pick < 90) begin
          issue(OP_TICK, clock_now, $urandom);
        end else if (pick < 95) begin
          issue(OP_CLEAR, clock_now, $urandom);
        end else begin
          issue(OP_LEAVE, clock_now, $urandom);
        end
      end
    end

    // drain and give stray results a chance to show up
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d input transactions under %0d window lengths, %0d results compared",
             items_sent, settings_done, compared);
    $display("%0d delayed triggers fired early on a full queue, %0d deadlines popped by ticks",
             skipped, popped);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
